>>> rtl/cmfs_pkg.sv
// Shared types and constants for the cube-map face select block.
`default_nettype none
package cmfs_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int UV_WIDTH    = 16;

  // magnitude and divisor (2*m) widths, remainder needs room for 2*d
  localparam int MAG_W = COORD_WIDTH + 1;
  localparam int DEN_W = COORD_WIDTH + 1;
  localparam int REM_W = COORD_WIDTH + 2;

  // cycles from an accepted request to its result strobe
  localparam int PIPE_LAT = UV_WIDTH + 1;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
  } in_req_t;

  typedef struct packed {
    logic [2:0]          face;
    logic [UV_WIDTH-1:0] u_coord;
    logic [UV_WIDTH-1:0] v_coord;
    logic                zero_vector;
  } out_res_t;

  // one slot of the divider chain: both coordinates move together
  typedef struct packed {
    logic                valid;
    face_t               face;
    logic                zero;
    logic [DEN_W-1:0]    den;
    logic [REM_W-1:0]    rem_u;
    logic [REM_W-1:0]    rem_v;
    logic [UV_WIDTH-1:0] quo_u;
    logic [UV_WIDTH-1:0] quo_v;
  } div_stage_t;

endpackage
`default_nettype wire

>>> rtl/cmfs_front.sv
// Front cell: major-axis face choice and divider operands, registered.
`default_nettype none
module cmfs_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   req_valid,
  input  cmfs_pkg::in_req_t     req,
  output cmfs_pkg::div_stage_t  stage_o
);
  import cmfs_pkg::*;

  logic signed [MAG_W-1:0] sx, sy, sz;
  logic [MAG_W-1:0]        ax, ay, az;
  logic                    sel_x, sel_y, sel_z, zero;
  logic signed [MAG_W-1:0] uc, vc;
  logic [MAG_W-1:0]        mag;
  face_t                   face;
  logic signed [MAG_W:0]   num_u, num_v;
  div_stage_t              stage_r, stage_nxt;

  // sign-extended components and magnitudes
  assign sx = {req.dir_x[COORD_WIDTH-1], req.dir_x};
  assign sy = {req.dir_y[COORD_WIDTH-1], req.dir_y};
  assign sz = {req.dir_z[COORD_WIDTH-1], req.dir_z};
  assign ax = sx[MAG_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
  assign ay = sy[MAG_W-1] ? MAG_W'(-sy) : MAG_W'(sy);
  assign az = sz[MAG_W-1] ? MAG_W'(-sz) : MAG_W'(sz);

  // later axis wins a tie
  assign sel_x = (ax >= ay) && (ax >= az);
  assign sel_y = (ay >= ax) && (ay >= az);
  assign sel_z = (az >= ax) && (az >= ay);
  assign zero  = (ax == '0) && (ay == '0) && (az == '0);

  // face and signed face components; zero counts as negative
  always_comb begin
    face = FACE_POS_X;
    uc   = '0;
    vc   = '0;
    mag  = ax;
    if (sel_z) begin
      mag = az;
      vc  = sy;
      if (sz > 0) begin
        face = FACE_POS_Z;
        uc   = sx;
      end else begin
        face = FACE_NEG_Z;
        uc   = -sx;
      end
    end else if (sel_y) begin
      mag = ay;
      uc  = sx;
      if (sy > 0) begin
        face = FACE_POS_Y;
        vc   = -sz;
      end else begin
        face = FACE_NEG_Y;
        vc   = sz;
      end
    end else if (sel_x) begin
      mag = ax;
      vc  = sy;
      if (sx > 0) begin
        face = FACE_POS_X;
        uc   = -sz;
      end else begin
        face = FACE_NEG_X;
        uc   = sz;
      end
    end
  end

  // numerators uc + m land in 0..2m
  assign num_u = {uc[MAG_W-1], uc} + $signed({1'b0, mag});
  assign num_v = {vc[MAG_W-1], vc} + $signed({1'b0, mag});

  // zero vector: numerator 0 over 1 yields a zero quotient
  always_comb begin
    stage_nxt       = stage_r;
    stage_nxt.valid = req_valid;
    stage_nxt.quo_u = '0;
    stage_nxt.quo_v = '0;
    if (zero) begin
      stage_nxt.face  = FACE_POS_X;
      stage_nxt.zero  = 1'b1;
      stage_nxt.den   = DEN_W'(1);
      stage_nxt.rem_u = '0;
      stage_nxt.rem_v = '0;
    end else begin
      stage_nxt.face  = face;
      stage_nxt.zero  = 1'b0;
      stage_nxt.den   = DEN_W'({mag, 1'b0});
      stage_nxt.rem_u = REM_W'(num_u[MAG_W:0]);
      stage_nxt.rem_v = REM_W'(num_v[MAG_W:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.face  <= stage_nxt.face;
    stage_r.zero  <= stage_nxt.zero;
    stage_r.den   <= stage_nxt.den;
    stage_r.rem_u <= stage_nxt.rem_u;
    stage_r.rem_v <= stage_nxt.rem_v;
    stage_r.quo_u <= stage_nxt.quo_u;
    stage_r.quo_v <= stage_nxt.quo_v;
  end

  assign stage_o = stage_r;

endmodule
`default_nettype wire

>>> rtl/cmfs_div_cell.sv
// Divider cell: one restoring quotient bit for u and for v, registered.
`default_nettype none
module cmfs_div_cell (
  input  wire                   clk,
  input  wire                   rst_n,
  input  cmfs_pkg::div_stage_t  stage_i,
  output cmfs_pkg::div_stage_t  stage_o
);
  import cmfs_pkg::*;

  logic [REM_W-1:0] dbl_u, dbl_v, den_ext;
  logic             bit_u, bit_v;
  div_stage_t       stage_r, stage_nxt;

  // remainder stays at or below den, so doubling fits
  assign den_ext = REM_W'(stage_i.den);
  assign dbl_u   = {stage_i.rem_u[REM_W-2:0], 1'b0};
  assign dbl_v   = {stage_i.rem_v[REM_W-2:0], 1'b0};
  assign bit_u   = dbl_u >= den_ext;
  assign bit_v   = dbl_v >= den_ext;

  always_comb begin
    stage_nxt       = stage_i;
    stage_nxt.rem_u = bit_u ? (dbl_u - den_ext) : dbl_u;
    stage_nxt.rem_v = bit_v ? (dbl_v - den_ext) : dbl_v;
    stage_nxt.quo_u = {stage_i.quo_u[UV_WIDTH-2:0], bit_u};
    stage_nxt.quo_v = {stage_i.quo_v[UV_WIDTH-2:0], bit_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.face  <= stage_nxt.face;
    stage_r.zero  <= stage_nxt.zero;
    stage_r.den   <= stage_nxt.den;
    stage_r.rem_u <= stage_nxt.rem_u;
    stage_r.rem_v <= stage_nxt.rem_v;
    stage_r.quo_u <= stage_nxt.quo_u;
    stage_r.quo_v <= stage_nxt.quo_v;
  end

  assign stage_o = stage_r;

endmodule
`default_nettype wire

>>> rtl/cube_map_face_select_top.sv
// Top level of the cube-map face select block: front cell and divider chain.
//
// Usage: drive in_req with a direction (three signed components, same scale)
// and raise start; the request is taken at any edge where start is high and
// busy is low. busy is always low, so a new request may be issued every
// cycle. Each request produces exactly one result: out_valid is high for one
// cycle with out_res holding face (0 +X .. 5 -Z), u_coord, v_coord and
// zero_vector. Results come out in request order.
// The request is registered in the front cell that picks the major axis, then
// each divider cell in a chain of UV_WIDTH cells adds one quotient bit.
// Throughput is one request per cycle.
// The coordinate at the upper edge of a face saturates to all ones; a zero
// vector reports face 0, u = v = 0 with zero_vector set.
// Synchronous reset clears every valid bit in the chain, dropping requests
// in flight. The receiver cannot stall: a result must be taken in the cycle
// it is strobed.
`default_nettype none
module cube_map_face_select_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  cmfs_pkg::in_req_t   in_req,
  output logic                out_valid,
  output cmfs_pkg::out_res_t  out_res
);
  import cmfs_pkg::*;

  div_stage_t chain [0:UV_WIDTH];

  assign busy = 1'b0;

  cmfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (start),
    .req       (in_req),
    .stage_o   (chain[0])
  );

  // one cell per quotient bit
  for (genvar i = 0; i < UV_WIDTH; i++) begin : g_cell
    cmfs_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // result from the last cell
  assign out_valid           = chain[UV_WIDTH].valid;
  assign out_res.face        = chain[UV_WIDTH].face;
  assign out_res.u_coord     = chain[UV_WIDTH].quo_u;
  assign out_res.v_coord     = chain[UV_WIDTH].quo_v;
  assign out_res.zero_vector = chain[UV_WIDTH].zero;

`ifndef ASSERT_OFF
  // every accepted request later produces a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(PIPE_LAT) out_valid)
    else $error("result missing after pipeline latency");

  // a result strobe needs a matching accepted request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, PIPE_LAT)) |-> $past(start, PIPE_LAT))
    else $error("result strobe without matching request");

  // zero vector reports face 0 and zero coordinates
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.zero_vector) |->
      (out_res.face == FACE_POS_X && out_res.u_coord == '0 && out_res.v_coord == '0))
    else $error("zero vector result not cleared");
`endif

endmodule
`default_nettype wire

>>> sim/cube_map_face_select_top_tb.sv
// Self-checking testbench for the cube-map face select block.
module cube_map_face_select_top_tb;
  import cmfs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = PIPE_LAT + 8;

  logic     clk    = 1'b0;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  in_req_t  in_req = '0;
  logic     out_valid;
  out_res_t out_res;

  out_res_t expected_faces[$];
  int       mismatch_count = 0;
  int       stall_cycles   = 0;

  cube_map_face_select_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // 10 unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor((c + m) * 2^UV_WIDTH / (2m)), saturated to all ones
  function automatic logic [UV_WIDTH-1:0] face_fraction(longint c, longint m);
    longint q;
    q = ((c + m) <<< UV_WIDTH) / (2 * m);
    if (q > (longint'(1) <<< UV_WIDTH) - 1)
      q = (longint'(1) <<< UV_WIDTH) - 1;
    return q[UV_WIDTH-1:0];
  endfunction

  // major axis face and face coordinates of one direction
  function automatic out_res_t predict_face_uv(in_req_t r);
    longint   x, y, z, ax, ay, az, m, uc, vc;
    face_t    f;
    out_res_t res;
    x  = longint'($signed(r.dir_x));
    y  = longint'($signed(r.dir_y));
    z  = longint'($signed(r.dir_z));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    res = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      res.zero_vector = 1'b1;
      return res;
    end
    m  = 0;
    uc = 0;
    vc = 0;
    f  = FACE_POS_X;
    // later tests override earlier ones, so ties go to the higher face
    if (ax >= ay && ax >= az) begin
      m  = ax;
      vc = y;
      if (x > 0) begin
        uc = -z;
        f  = FACE_POS_X;
      end else begin
        uc = z;
        f  = FACE_NEG_X;
      end
    end
    if (ay >= ax && ay >= az) begin
      m  = ay;
      uc = x;
      if (y > 0) begin
        vc = -z;
        f  = FACE_POS_Y;
      end else begin
        vc = z;
        f  = FACE_NEG_Y;
      end
    end
    if (az >= ax && az >= ay) begin
      m  = az;
      vc = y;
      if (z > 0) begin
        uc = x;
        f  = FACE_POS_Z;
      end else begin
        uc = -x;
        f  = FACE_NEG_Z;
      end
    end
    res.face    = f;
    res.u_coord = face_fraction(uc, m);
    res.v_coord = face_fraction(vc, m);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // compare every strobed result with the oldest pending prediction
  always @(posedge clk) begin : check_results
    out_res_t want;
    if (rst_n && out_valid) begin
      if (expected_faces.size() == 0) begin
        report_mismatch("unexpected result, face", -1, out_res.face);
      end else begin
        want = expected_faces.pop_front();
        if (out_res.face !== want.face)
          report_mismatch("face", want.face, out_res.face);
        if (out_res.u_coord !== want.u_coord)
          report_mismatch("u_coord", want.u_coord, out_res.u_coord);
        if (out_res.v_coord !== want.v_coord)
          report_mismatch("v_coord", want.v_coord, out_res.v_coord);
        if (out_res.zero_vector !== want.zero_vector)
          report_mismatch("zero_vector", want.zero_vector, out_res.zero_vector);
      end
    end
  end

  // watchdog: cycles with neither a request taken nor a result strobed
  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("cube_map_face_select_top: mismatch");
      $finish;
    end
  end

  // hold one request until taken; start stays high for a following request
  task automatic send_direction(in_req_t r);
    in_req <= r;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_faces.push_back(predict_face_uv(r));
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic in_req_t make_dir(int x, int y, int z);
    in_req_t r;
    r.dir_x = clamp_coord(x);
    r.dir_y = clamp_coord(y);
    r.dir_z = clamp_coord(z);
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // drop start for a while, with junk on the request bus
  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      start  <= 1'b0;
      in_req <= in_req_t'({$urandom(), $urandom()});
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_list(in_req_t reqs[$]);
    foreach (reqs[i]) begin
      send_direction(reqs[i]);
      idle_gap(random_gap());
    end
  endtask

  // zero vector, each face at the component extremes, zero components
  task automatic test_faces_and_zero();
    in_req_t reqs[$];
    reqs.push_back(make_dir(0, 0, 0));
    reqs.push_back(make_dir(32767, 1, -1));
    reqs.push_back(make_dir(-32768, 32767, 0));
    reqs.push_back(make_dir(3, 32767, -2));
    reqs.push_back(make_dir(0, -32768, 0));
    reqs.push_back(make_dir(-1, 0, 32767));
    reqs.push_back(make_dir(0, 0, -32768));
    reqs.push_back(make_dir(1, 0, 0));
    reqs.push_back(make_dir(0, -1, 0));
    send_list(reqs);
  endtask

  // equal magnitudes resolve to the higher face
  task automatic test_ties();
    in_req_t reqs[$];
    reqs.push_back(make_dir(5, 5, 5));
    reqs.push_back(make_dir(5, -5, 0));
    reqs.push_back(make_dir(-7, 7, -7));
    reqs.push_back(make_dir(32767, 32767, 0));
    reqs.push_back(make_dir(-32768, -32768, -32768));
    reqs.push_back(make_dir(-32768, 100, -32768));
    send_list(reqs);
  endtask

  // coordinates at the lower edge and at the saturating upper edge
  task automatic test_face_edges();
    in_req_t reqs[$];
    reqs.push_back(make_dir(100, 0, 100));
    reqs.push_back(make_dir(-100, 0, 100));
    reqs.push_back(make_dir(1, 1, 1));
    reqs.push_back(make_dir(-32768, -32768, 32767));
    reqs.push_back(make_dir(32767, -32767, -32767));
    send_list(reqs);
  endtask

  function automatic int random_small();
    return int'($urandom_range(0, 6)) - 3;
  endfunction

  function automatic int random_extreme();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  // one dominant axis, others inside its range, often tied with it
  function automatic in_req_t random_dominant();
    int comp[3];
    int axis, m, sgn;
    axis = $urandom_range(0, 2);
    m    = $urandom_range(1, 32768);
    sgn  = (m == 32768 || $urandom_range(0, 1)) ? -1 : 1;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 3) == 0)
        comp[i] = $urandom_range(0, 1) ? m : -m;
      else
        comp[i] = int'($urandom_range(0, 2 * m)) - m;
    end
    comp[axis] = sgn * m;
    return make_dir(comp[0], comp[1], comp[2]);
  endfunction

  task automatic test_random_full(int count);
    repeat (count) begin
      send_direction(in_req_t'({$urandom(), $urandom()}));
      idle_gap(random_gap());
    end
  endtask

  task automatic test_random_small(int count);
    repeat (count) begin
      send_direction(make_dir(random_small(), random_small(), random_small()));
      idle_gap(random_gap());
    end
  endtask

  task automatic test_random_dominant(int count);
    repeat (count) begin
      send_direction(random_dominant());
      idle_gap(random_gap());
    end
  endtask

  // back-to-back requests with no gaps, extreme values
  task automatic test_burst_extremes(int count);
    repeat (count)
      send_direction(make_dir(random_extreme(), random_extreme(), random_extreme()));
    idle_gap(random_gap());
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_faces.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_faces_and_zero();
    test_ties();
    test_face_edges();
    test_random_full(200);
    test_random_small(80);
    test_random_dominant(220);
    test_burst_extremes(50);
    drain_results();
    if (mismatch_count == 0)
      $display("cube_map_face_select_top: match");
    else
      $display("cube_map_face_select_top: mismatch");
    $finish;
  end

endmodule
